// ===== hdl/lfo_pkg.sv =====
// Shared types and constants for the LFO waveform generator.
// Holds the waveform codes and the configuration register map.
// No dependencies; used by lfo_shape and lfo_waveform_generator_core.
`default_nettype none

package lfo_pkg;

    // Width of the configuration write data and register index.
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Width of the cycle length register and the sample index.
    localparam int INDEX_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] RST_PHASE_INC = 24'd1;
    localparam logic [INDEX_W-1:0]    RST_CYCLE_LEN = 16'hFFFF;

    // Waveform selection codes.
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } t_wave;

endpackage

`default_nettype wire

// ===== hdl/lfo_shape.sv =====
// Waveform shaper: maps one phase value to a signed fixed-point sample.
// Purely combinational; one 31x31 squaring for the parabolic sine.
// Depends on lfo_pkg for the waveform codes.
`default_nettype none

module lfo_shape #(
    parameter int PHASE_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic [PHASE_BITS-1:0]  i_phase,
    input  wire lfo_pkg::t_wave         i_waveform,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int H = SAMPLE_BITS - 1;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {H{1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {H{1'b0}}};

    logic                    ph_low;
    logic [PHASE_BITS+1:0]   four;
    logic [PHASE_BITS+1:0]   pivot;
    logic [PHASE_BITS+2:0]   delta;
    logic [PHASE_BITS+2:0]   delta_abs;
    logic [PHASE_BITS:0]     u;
    logic                    delta_neg;
    logic                    delta_pos;
    logic [PHASE_BITS+30:0]  u_wide;
    logic [30:0]             v;
    logic [61:0]             v_sq;
    logic [60:0]             one_minus;
    logic [H:0]              sine_mag;
    logic [PHASE_BITS+H:0]   tri_wide;
    logic [H:0]              tri_mag;
    logic [PHASE_BITS+H-1:0] saw_wide;
    logic                    tri_neg;

    // Distance of 4p from the nearer peak (1 below one half, 3 above).
    always_comb begin
        ph_low    = ~i_phase[PHASE_BITS-1];
        four      = {i_phase, 2'b00};
        pivot     = ph_low ? {2'b01, {PHASE_BITS{1'b0}}} : {2'b11, {PHASE_BITS{1'b0}}};
        delta     = {1'b0, four} - {1'b0, pivot};
        delta_neg = delta[PHASE_BITS+2];
        delta_pos = ~delta_neg && (delta != '0);
        delta_abs = delta_neg ? (~delta + 1'b1) : delta;
        u         = delta_abs[PHASE_BITS:0];
    end

    // Parabolic sine: magnitude 1 - u^2 in a 30-bit fraction, truncated.
    always_comb begin
        u_wide    = {u, 30'd0};
        v         = u_wide[PHASE_BITS+30:PHASE_BITS];
        v_sq      = v * v;
        one_minus = {1'b1, 60'd0} - v_sq[60:0];
        sine_mag  = one_minus[60:60-H];
    end

    // Triangle and sawtooth magnitudes, truncated to the output fraction.
    always_comb begin
        tri_wide = {u, {H{1'b0}}};
        tri_mag  = tri_wide[PHASE_BITS+H:PHASE_BITS];
        saw_wide = {i_phase, {H{1'b0}}};
        tri_neg  = ph_low ? delta_neg : delta_pos;
    end

    // Apply sign and saturate the positive full-scale value.
    always_comb begin
        case (i_waveform)
            lfo_pkg::WAVE_SINE: begin
                if (!ph_low) begin
                    o_sample = -$signed(sine_mag);
                end else begin
                    o_sample = sine_mag[H] ? S_MAX : $signed(sine_mag);
                end
            end
            lfo_pkg::WAVE_TRIANGLE: begin
                if (tri_neg) begin
                    o_sample = -$signed(tri_mag);
                end else begin
                    o_sample = tri_mag[H] ? S_MAX : $signed(tri_mag);
                end
            end
            lfo_pkg::WAVE_SQUARE: begin
                o_sample = ph_low ? S_MAX : S_MIN;
            end
            lfo_pkg::WAVE_SAWTOOTH: begin
                o_sample = $signed({1'b0, saw_wide[PHASE_BITS+H-1:PHASE_BITS]});
            end
            default: begin
                o_sample = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/lfo_waveform_generator_core.sv =====
// Top level of the LFO waveform generator: phase accumulator, cycle counter,
// configuration registers and a two-register pipeline around lfo_shape.
// Depends on lfo_pkg and lfo_shape.
//
//   Channel  | Direction | Handshake                  | Payload
//   ---------+-----------+----------------------------+---------------------------
//   cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//   in       | in        | i_in_valid / o_in_ready    | i_restart
//   out      | out       | o_out_valid / i_out_ready  | o_sample, o_cycle_start
//
// One transaction is accepted per clock unless the output stalls; each yields
// exactly one result. The input register captures the phase, and the result
// register captures the shaped sample after one squaring in lfo_shape.
// A stalled output holds its result while the input register still takes one
// more transaction. Reset is synchronous, clears phase, index and pipeline
// valids, and restores the configuration defaults. The cfg port is always ready.
`default_nettype none

module lfo_waveform_generator_core #(
    parameter int PHASE_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lfo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [lfo_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_restart,
    // Output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]            o_sample,
    output logic                                     o_cycle_start
);

    localparam int IW = lfo_pkg::INDEX_W;
    localparam int DW = lfo_pkg::CFG_DATA_W;

    // Configuration registers
    logic [DW-1:0]   r_phase_inc;
    logic [IW-1:0]   r_cycle_len;
    lfo_pkg::t_wave  r_waveform;

    // Oscillator state
    logic [PHASE_BITS-1:0] r_phase;
    logic [IW-1:0]         r_idx;
    logic [PHASE_BITS-1:0] n_phase;
    logic [IW-1:0]         n_idx;

    // Input register stage
    logic                  r_s1_valid;
    logic [PHASE_BITS-1:0] r_s1_phase;
    logic                  r_s1_start;

    // Result register stage
    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                         r_cycle_start;

    logic                          in_fire;
    logic                          s1_move;
    logic [PHASE_BITS-1:0]         ph_eff;
    logic [IW-1:0]                 idx_eff;
    logic [IW-1:0]                 idx_inc;
    logic [PHASE_BITS+DW-1:0]      inc_wide;
    logic [PHASE_BITS-1:0]         inc;
    logic signed [SAMPLE_BITS-1:0] shaped;

    // Handshakes: the input register moves on whenever the result register frees up.
    assign o_cfg_ready = 1'b1;
    assign s1_move     = ~r_out_valid | i_out_ready;
    assign o_in_ready  = ~r_s1_valid | s1_move;
    assign in_fire     = i_in_valid & o_in_ready;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= lfo_pkg::RST_PHASE_INC;
            r_cycle_len <= lfo_pkg::RST_CYCLE_LEN;
            r_waveform  <= lfo_pkg::WAVE_SINE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfo_pkg::CFG_PHASE_INC: r_phase_inc <= i_cfg_data;
                lfo_pkg::CFG_CYCLE_LEN: r_cycle_len <= i_cfg_data[IW-1:0];
                lfo_pkg::CFG_WAVEFORM:  r_waveform  <= lfo_pkg::t_wave'(i_cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    // Phase step sized to the accumulator width.
    assign inc_wide = {{PHASE_BITS{1'b0}}, r_phase_inc};
    assign inc      = inc_wide[PHASE_BITS-1:0];

    // Next accumulator and index; reaching the cycle length replays from zero.
    always_comb begin
        ph_eff  = i_restart ? '0 : r_phase;
        idx_eff = i_restart ? '0 : r_idx;
        idx_inc = idx_eff + 1'b1;
        if ((idx_inc >= r_cycle_len) || (idx_inc == '0)) begin
            n_idx   = '0;
            n_phase = '0;
        end else begin
            n_idx   = idx_inc;
            n_phase = ph_eff + inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_idx   <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    // Input register: phase and cycle-start flag of the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_phase <= ph_eff;
            r_s1_start <= (idx_eff == '0);
        end
    end

    lfo_shape #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_shape (
        .i_phase    (r_s1_phase),
        .i_waveform (r_waveform),
        .o_sample   (shaped)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_valid) begin
            r_sample      <= shaped;
            r_cycle_start <= r_s1_start;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample      = r_sample;
    assign o_cycle_start = r_cycle_start;

    // A zero sample index always comes with a zero phase.
    a_idx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx == '0) |-> (r_phase == '0))
        else $error("sample index is zero but phase is not");

    // A restart transaction starts a cycle at phase zero.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_restart) |=> (r_s1_start && (r_s1_phase == '0)))
        else $error("restart did not reach the input register");

    // A blocked input register keeps its transaction.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> r_s1_valid)
        else $error("input register dropped a transaction");

    // The square wave only ever shows the two full-scale values.
    a_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_waveform == lfo_pkg::WAVE_SQUARE)) |->
        ((o_sample == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
         (o_sample == {1'b1, {(SAMPLE_BITS-1){1'b0}}})))
        else $error("square wave off full scale");

    // The sawtooth never goes negative.
    a_saw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_waveform == lfo_pkg::WAVE_SAWTOOTH)) |->
        !o_sample[SAMPLE_BITS-1])
        else $error("sawtooth went negative");

endmodule

`default_nettype wire

// ===== bench/lfo_waveform_generator_core_test.sv =====
// Self-checking testbench for lfo_waveform_generator_core: drives ticks and register
// writes with random idling, predicts every sample and checks it on the output channel.
// Depends on lfo_pkg and the RTL of lfo_waveform_generator_core.
`default_nettype none

// One expected oscillator sample.
typedef struct {
    logic signed [15:0] sample;
    logic               cycle_start;
} t_lfo_tick;

// Tracks the oscillator state and the samples still due from the block.
class lfo_tick_scoreboard;
    logic [23:0]    phase_inc;
    logic [15:0]    cycle_len;
    lfo_pkg::t_wave wave;
    logic [23:0]    phase;
    logic [15:0]    idx;
    t_lfo_tick      due_ticks[$];
    int             errors;

    function new();
        phase_inc = lfo_pkg::RST_PHASE_INC;
        cycle_len = lfo_pkg::RST_CYCLE_LEN;
        wave      = lfo_pkg::WAVE_SINE;
        phase     = '0;
        idx       = '0;
        errors    = 0;
    endfunction

    // Mirrors a register write; an unmapped index changes nothing.
    function void set_reg(logic [lfo_pkg::CFG_IDX_W-1:0] index,
                          logic [lfo_pkg::CFG_DATA_W-1:0] data);
        case (index)
            lfo_pkg::CFG_PHASE_INC: phase_inc = data;
            lfo_pkg::CFG_CYCLE_LEN: cycle_len = data[15:0];
            lfo_pkg::CFG_WAVEFORM:  wave = lfo_pkg::t_wave'(data[1:0]);
            default: ;
        endcase
    endfunction

    // Oscillator level in Q1.15 for a phase, with the current shape.
    function logic signed [15:0] level_at(logic [23:0] ph);
        longint unsigned full, half, p, four, u, v, mag;
        longint          s;
        bit              neg;
        full = 64'h100_0000;
        half = 64'h80_0000;
        p    = ph;
        four = p * 4;
        case (wave)
            lfo_pkg::WAVE_SINE: begin
                neg = (p >= half);
                if (!neg) begin
                    u = (four >= full) ? four - full : full - four;
                end else begin
                    u = (four >= 3 * full) ? four - 3 * full : 3 * full - four;
                end
                // Distance from the peak as a 30-bit fraction, then 1 - u^2.
                v   = u << 6;
                mag = ((64'd1 << 60) - v * v) >> 45;
            end
            lfo_pkg::WAVE_TRIANGLE: begin
                if (p < half) begin
                    neg = (four < full);
                    u   = neg ? full - four : four - full;
                end else begin
                    neg = (four > 3 * full);
                    u   = neg ? four - 3 * full : 3 * full - four;
                end
                mag = (u << 15) >> 24;
            end
            lfo_pkg::WAVE_SQUARE: begin
                neg = (p >= half);
                mag = 64'd1 << 15;
            end
            default: begin
                neg = 1'b0;
                mag = (p << 15) >> 24;
            end
        endcase
        // Apply the sign and saturate full scale.
        s = neg ? -longint'(mag) : longint'(mag);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[15:0];
    endfunction

    // Notes an accepted tick: queues its sample and advances the oscillator.
    function void note_tick(logic restart);
        t_lfo_tick due;
        if (restart) begin
            phase = '0;
            idx   = '0;
        end
        due.sample      = level_at(phase);
        due.cycle_start = (idx == 16'd0);
        due_ticks.push_back(due);
        phase = phase + phase_inc;
        idx   = idx + 16'd1;
        // The cycle replays from phase zero once the index reaches the length.
        if (idx >= cycle_len || idx == 16'd0) begin
            idx   = '0;
            phase = '0;
        end
    endfunction

    // Checks one delivered sample against the oldest one due.
    function void check_tick(logic signed [15:0] sample, logic cycle_start);
        t_lfo_tick due;
        if (due_ticks.size() == 0) begin
            $error("sample: unexpected result %0d, cycle_start %0b, none pending",
                   sample, cycle_start);
            errors++;
            return;
        end
        due = due_ticks.pop_front();
        if (sample !== due.sample) begin
            $error("sample: expected %0d, got %0d", due.sample, sample);
            errors++;
        end
        if (cycle_start !== due.cycle_start) begin
            $error("cycle_start: expected %0b, got %0b", due.cycle_start, cycle_start);
            errors++;
        end
    endfunction

    function int waiting();
        return due_ticks.size();
    endfunction
endclass

module lfo_waveform_generator_core_test;

    // Register index with no register behind it.
    localparam logic [lfo_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [lfo_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [lfo_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_restart;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic signed [15:0]             o_sample;
    logic                           o_cycle_start;

    lfo_tick_scoreboard ticks = new();
    bit                 calm = 1'b0;

    lfo_waveform_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample      (o_sample),
        .o_cycle_start (o_cycle_start)
    );

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offers one tick after an optional idle burst and waits for its transaction.
    task automatic send_tick(logic restart);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        ticks.note_tick(restart);
    endtask

    // One register write transaction; valid stays high for a following write.
    task automatic cfg_write(logic [lfo_pkg::CFG_IDX_W-1:0] index,
                             logic [lfo_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ticks.set_reg(index, data);
    endtask

    // Writes all registers; unused upper data bits are filled at random.
    task automatic apply(logic [23:0] inc, logic [15:0] len, lfo_pkg::t_wave wv,
                         bit spare);
        cfg_write(lfo_pkg::CFG_PHASE_INC, inc);
        cfg_write(lfo_pkg::CFG_CYCLE_LEN, {8'($urandom), len});
        cfg_write(lfo_pkg::CFG_WAVEFORM, {22'($urandom), wv});
        if (spare) cfg_write(CFG_SPARE, 24'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering ticks and waits until every sample has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ticks.waiting() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiver: checks each result and stalls in bursts, with two long hold-offs.
    initial begin : receiver
        int stall;
        int seen;
        stall = 0;
        seen  = 0;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                ticks.check_tick(o_sample, o_cycle_start);
                seen++;
                if (seen == 400 || seen == 1300) stall = 64;
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 8) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus: directed corners first, then random phases of settings.
    initial begin : stimulus
        int          total;
        int          count;
        logic [23:0] inc;
        logic [15:0] len;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_restart   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= lfo_pkg::CFG_PHASE_INC;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: unit step, sine, longest cycle.
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);

        // Quarter steps land on the zero crossings and peaks of sine and triangle.
        settle();
        apply(24'h400000, 16'hFFFF, lfo_pkg::WAVE_SINE, 1'b0);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        settle();
        apply(24'h400000, 16'hFFFF, lfo_pkg::WAVE_TRIANGLE, 1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // Square around the half point, with a write to the unmapped index.
        settle();
        apply(24'h7FFFFF, 16'hFFFF, lfo_pkg::WAVE_SQUARE, 1'b1);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);

        // Largest step: the phase wraps on every tick.
        settle();
        apply(24'hFFFFFF, 16'hFFFF, lfo_pkg::WAVE_SAWTOOTH, 1'b0);
        repeat (3) send_tick(1'b0);

        // Length lowered below the running index, then a zero length.
        settle();
        apply(24'h123457, 16'd2, lfo_pkg::WAVE_SINE, 1'b0);
        repeat (3) send_tick(1'b0);
        settle();
        apply(24'h000000, 16'd0, lfo_pkg::WAVE_TRIANGLE, 1'b1);
        repeat (2) send_tick(1'b0);

        // Random phases; the last stretch runs without idling.
        total = 23;
        while (total < 1900) begin
            settle();
            if (total >= 1700) calm = 1'b1;
            case ($urandom_range(0, 4))
                0:       inc = 24'h000000;
                1:       inc = 24'hFFFFFF;
                2:       inc = 24'd1 << $urandom_range(0, 23);
                default: inc = 24'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       len = 16'd0;
                1:       len = 16'd1;
                2:       len = 16'hFFFF;
                3:       len = 16'($urandom_range(2, 8));
                4:       len = 16'($urandom_range(2, 100));
                default: len = 16'($urandom);
            endcase
            apply(inc, len, lfo_pkg::t_wave'($urandom_range(0, 3)),
                  $urandom_range(0, 3) == 0);
            count = $urandom_range(15, 80);
            repeat (count) send_tick($urandom_range(0, 15) == 0);
            total += count;
        end

        settle();
        if (ticks.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog in case a handshake never completes.
    initial begin : watchdog
        #(12 * 500000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
